// ----- rtl/core/tdba_pkg.sv -----
// Shared types, constants and helpers of the two-direction batch arbiter.
`default_nettype none
package tdba_pkg;

  localparam int unsigned COUNT_BITS = 8;
  localparam int unsigned MB_BITS    = 8;
  localparam int unsigned OUT_BITS   = 8;
  localparam int unsigned LIM_BITS   = (COUNT_BITS > MB_BITS) ? COUNT_BITS : MB_BITS;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  localparam logic [1:0] DIR_ZERO = 2'd0;
  localparam logic [1:0] DIR_ONE  = 2'd1;
  localparam logic [1:0] DIR_NONE = 2'd2;

  localparam logic [1:0] FAULT_OK    = 2'd0;
  localparam logic [1:0] FAULT_SAT   = 2'd1;
  localparam logic [1:0] FAULT_EMPTY = 2'd2;

  localparam logic KIND_ARRIVE = 1'b0;
  localparam logic KIND_LEAVE  = 1'b1;

  localparam logic [MB_BITS-1:0] BATCH_CAP_RESET = 8'd4;

  typedef struct packed {
    logic [COUNT_BITS-1:0] wait_zero;
    logic [COUNT_BITS-1:0] wait_one;
    logic [COUNT_BITS-1:0] occ;
    logic [1:0]            open_dir;
    logic [COUNT_BITS-1:0] batch;
    logic                  pref_dir;
  } arb_state_t;

  typedef struct packed {
    logic                grant_direction;
    logic [OUT_BITS-1:0] grant_count;
    logic [OUT_BITS-1:0] occupancy;
    logic [OUT_BITS-1:0] waiting_zero;
    logic [OUT_BITS-1:0] waiting_one;
    logic [1:0]          open_direction;
    logic [1:0]          fault;
  } arb_result_t;

  function automatic logic [OUT_BITS-1:0] low_out(input logic [COUNT_BITS-1:0] v);
    logic [COUNT_BITS+OUT_BITS-1:0] t;
    t = {{OUT_BITS{1'b0}}, v};
    return t[OUT_BITS-1:0];
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/tdba_ifs.sv -----
// Channel interfaces of the two-direction batch arbiter: events, results, configuration.
`default_nettype none
interface tdba_evt_if;
  logic valid;
  logic ready;
  logic kind;
  logic direction;
  modport source (output valid, output kind, output direction, input ready);
  modport sink (input valid, input kind, input direction, output ready);
endinterface

interface tdba_res_if
  import tdba_pkg::*;
;
  logic                valid;
  logic                ready;
  logic                grant_direction;
  logic [OUT_BITS-1:0] grant_count;
  logic [OUT_BITS-1:0] occupancy;
  logic [OUT_BITS-1:0] waiting_zero;
  logic [OUT_BITS-1:0] waiting_one;
  logic [1:0]          open_direction;
  logic [1:0]          fault;
  modport source (output valid, output grant_direction, output grant_count,
                  output occupancy, output waiting_zero, output waiting_one,
                  output open_direction, output fault, input ready);
  modport sink (input valid, input grant_direction, input grant_count,
                input occupancy, input waiting_zero, input waiting_one,
                input open_direction, input fault, output ready);
endinterface

interface tdba_cfg_if
  import tdba_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [MB_BITS-1:0] batch_cap;
  modport source (output valid, output batch_cap, input ready);
  modport sink (input valid, input batch_cap, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/tdba_step.sv -----
// Next-state and result logic for one arrive or leave event.
`default_nettype none
module tdba_step
  import tdba_pkg::*;
(
  input  arb_state_t         state_i,
  input  logic               kind_i,
  input  logic               dir_i,
  input  logic [MB_BITS-1:0] batch_cap_i,
  output arb_state_t         state_o,
  output arb_result_t        result_o
);

  logic [COUNT_BITS-1:0] w0, w1, occ, batch, bb, wc, wo, room, n, wd_r, wo_r;
  logic [COUNT_BITS:0]   bsum;
  logic [LIM_BITS-1:0]   mb, lim, nl;
  logic [1:0]            od, fault;
  logic                  pref, c, ok, opening, sel, gdir;

  always_comb begin
    w0      = state_i.wait_zero;
    w1      = state_i.wait_one;
    occ     = state_i.occ;
    batch   = state_i.batch;
    od      = state_i.open_dir;
    pref    = state_i.pref_dir;
    fault   = FAULT_OK;
    mb      = LIM_BITS'((batch_cap_i == '0) ? MB_BITS'(1) : batch_cap_i);
    c       = 1'b0;
    bb      = '0;
    ok      = 1'b0;
    opening = 1'b0;
    sel     = 1'b0;
    wd_r    = dir_i ? w1 : w0;
    wo_r    = dir_i ? w0 : w1;
    wc      = '0;
    wo      = '0;
    room    = '0;
    lim     = '0;
    nl      = '0;
    n       = '0;
    bsum    = '0;
    gdir    = 1'b0;

    if (kind_i == KIND_ARRIVE) begin
      if (dir_i) begin
        if (w1 == COUNT_MAX) fault = FAULT_SAT;
        else w1 = w1 + COUNT_BITS'(1);
      end else begin
        if (w0 == COUNT_MAX) fault = FAULT_SAT;
        else w0 = w0 + COUNT_BITS'(1);
      end
    end else begin
      if (occ == '0) begin
        fault = FAULT_EMPTY;
      end else begin
        occ = occ - COUNT_BITS'(1);
        if (occ == '0) begin
          if (wd_r == '0 && wo_r == '0) begin
            od = DIR_NONE;
          end else if (wd_r == '0) begin
            od   = {1'b0, ~dir_i};
            pref = dir_i;
          end else if (wo_r == '0) begin
            od   = {1'b0, dir_i};
            pref = ~dir_i;
          end else begin
            sel  = (LIM_BITS'(batch) >= mb) ? ~dir_i : pref;
            od   = {1'b0, sel};
            pref = ~sel;
          end
          batch = '0;
        end
      end
    end

    if (od == DIR_ZERO || od == DIR_ONE) begin
      c  = od[0];
      bb = batch;
      ok = 1'b1;
    end else if (occ == '0) begin
      c       = (w0 != '0 && w1 != '0) ? pref : (w1 != '0);
      ok      = 1'b1;
      opening = 1'b1;
    end

    if (ok) begin
      wc   = c ? w1 : w0;
      wo   = c ? w0 : w1;
      room = COUNT_MAX - occ;
      nl   = LIM_BITS'(wc);
      if (wo != '0) begin
        lim = (LIM_BITS'(bb) >= mb) ? '0 : mb - LIM_BITS'(bb);
        if (nl > lim) nl = lim;
      end
      n = COUNT_BITS'(nl);
      if (n > room) begin
        n = room;
        if (fault == FAULT_OK) fault = FAULT_SAT;
      end
      if (n != '0) begin
        if (opening) od = {1'b0, c};
        if (c) w1 = w1 - n;
        else w0 = w0 - n;
        occ   = occ + n;
        bsum  = {1'b0, bb} + {1'b0, n};
        batch = bsum[COUNT_BITS] ? COUNT_MAX : bsum[COUNT_BITS-1:0];
        gdir  = c;
      end
    end

    state_o.wait_zero = w0;
    state_o.wait_one  = w1;
    state_o.occ       = occ;
    state_o.open_dir  = od;
    state_o.batch     = batch;
    state_o.pref_dir  = pref;

    result_o.grant_direction = gdir;
    result_o.grant_count     = low_out(n);
    result_o.occupancy       = low_out(occ);
    result_o.waiting_zero    = low_out(w0);
    result_o.waiting_one     = low_out(w1);
    result_o.open_direction  = od;
    result_o.fault           = fault;
  end

endmodule
`default_nettype wire

// ----- rtl/core/two_direction_batch_arbiter_core.sv -----
// Top level of the two-direction batch arbiter: event register, state, result register.
// The arbiter takes one arrive or leave event per cycle unless the result channel stalls,
// and returns one result per event, through the event register and then the state update
// and grant logic into the result register; the state registers loop through that logic,
// which sets the rate. The user must write the batch cap through the configuration channel
// only while no event is in flight; the block itself does not enforce this.
`default_nettype none
module two_direction_batch_arbiter_core
  import tdba_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  tdba_evt_if.sink   evt_i,
  tdba_cfg_if.sink   cfg_i,
  tdba_res_if.source res_o
);

  logic               evt_valid_q;
  logic               kind_q, dir_q;
  logic               res_valid_q;
  arb_result_t        res_q, res_d;
  arb_state_t         state_q, state_d;
  logic [MB_BITS-1:0] batch_cap_q;
  logic               advance;

  assign advance     = evt_valid_q && (!res_valid_q || res_o.ready);
  assign evt_i.ready = !evt_valid_q || advance;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      evt_valid_q <= 1'b0;
    end else if (evt_i.ready) begin
      evt_valid_q <= evt_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (evt_i.valid && evt_i.ready) begin
      kind_q <= evt_i.kind;
      dir_q  <= evt_i.direction;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      batch_cap_q <= BATCH_CAP_RESET;
    end else if (cfg_i.valid) begin
      batch_cap_q <= cfg_i.batch_cap;
    end
  end

  tdba_step u_step (
    .state_i     (state_q),
    .kind_i      (kind_q),
    .dir_i       (dir_q),
    .batch_cap_i (batch_cap_q),
    .state_o     (state_d),
    .result_o    (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.wait_zero <= '0;
      state_q.wait_one  <= '0;
      state_q.occ       <= '0;
      state_q.open_dir  <= DIR_NONE;
      state_q.batch     <= '0;
      state_q.pref_dir  <= 1'b0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (!res_valid_q || res_o.ready) begin
      res_valid_q <= evt_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid           = res_valid_q;
  assign res_o.grant_direction = res_q.grant_direction;
  assign res_o.grant_count     = res_q.grant_count;
  assign res_o.occupancy       = res_q.occupancy;
  assign res_o.waiting_zero    = res_q.waiting_zero;
  assign res_o.waiting_one     = res_q.waiting_one;
  assign res_o.open_direction  = res_q.open_direction;
  assign res_o.fault           = res_q.fault;

`ifndef SYNTHESIS
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(state_q))
    else $error("arbiter state changed without an event");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> res_valid_q)
    else $error("processed event produced no result");

  a_closed_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.open_dir == DIR_NONE) |-> (state_q.occ == '0))
    else $error("resource occupied with no open direction");
`endif

endmodule
`default_nettype wire

// ----- verif/tdba_grant_checker.sv -----
// Checker for the two-direction batch arbiter: predicts each result and compares it.
module tdba_grant_checker
  import tdba_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  tdba_evt_if         evt_i,
  tdba_cfg_if         cfg_i,
  tdba_res_if         res_i,
  output int unsigned errors_o,
  output int unsigned pending_o
);

  localparam int unsigned CNT_TOP = (1 << COUNT_BITS) - 1;

  int unsigned        wait_cnt [2];
  int unsigned        occ_cnt;
  logic [1:0]         open_dir_q;
  int unsigned        batch_cnt;
  logic               pref_q;
  logic [MB_BITS-1:0] batch_cap_q;

  arb_result_t predicted_results [$];
  arb_result_t oldest;
  int unsigned mismatch_cnt = 0;
  int unsigned result_idx = 0;

  assign errors_o = mismatch_cnt;

  function automatic arb_result_t next_grant(logic kind, logic dir);
    int unsigned cap, w_same, w_other, base, grant, lim, room;
    logic        cand, usable, opening;
    logic [1:0]  flt;
    arb_result_t r;
    cap     = (batch_cap_q == 0) ? 1 : batch_cap_q;
    flt     = FAULT_OK;
    cand    = 1'b0;
    base    = 0;
    grant   = 0;
    usable  = 1'b0;
    opening = 1'b0;
    if (kind == KIND_ARRIVE) begin
      if (wait_cnt[dir] >= CNT_TOP) flt = FAULT_SAT;
      else wait_cnt[dir]++;
    end else if (occ_cnt == 0) begin
      flt = FAULT_EMPTY;
    end else begin
      occ_cnt--;
      if (occ_cnt == 0) begin
        w_same  = wait_cnt[dir];
        w_other = wait_cnt[~dir];
        if (w_same == 0 && w_other == 0) begin
          open_dir_q = DIR_NONE;
        end else if (w_same == 0) begin
          open_dir_q = {1'b0, ~dir};
          pref_q     = dir;
        end else if (w_other == 0) begin
          open_dir_q = {1'b0, dir};
          pref_q     = ~dir;
        end else begin
          open_dir_q = (batch_cnt >= cap) ? {1'b0, ~dir} : {1'b0, pref_q};
          pref_q     = ~open_dir_q[0];
        end
        batch_cnt = 0;
      end
    end

    if (open_dir_q != DIR_NONE) begin
      cand   = open_dir_q[0];
      base   = batch_cnt;
      usable = 1'b1;
    end else if (occ_cnt == 0) begin
      cand    = (wait_cnt[0] > 0 && wait_cnt[1] > 0) ? pref_q : logic'(wait_cnt[1] > 0);
      usable  = 1'b1;
      opening = 1'b1;
    end

    if (usable) begin
      grant = wait_cnt[cand];
      if (wait_cnt[~cand] > 0) begin
        lim = (base >= cap) ? 0 : cap - base;
        if (grant > lim) grant = lim;
      end
      room = CNT_TOP - occ_cnt;
      if (grant > room) begin
        grant = room;
        if (flt == FAULT_OK) flt = FAULT_SAT;
      end
      if (grant > 0) begin
        if (opening) open_dir_q = {1'b0, cand};
        wait_cnt[cand] -= grant;
        occ_cnt        += grant;
        base           += grant;
        batch_cnt       = (base > CNT_TOP) ? CNT_TOP : base;
      end
    end

    r.grant_direction = (grant > 0) ? cand : 1'b0;
    r.grant_count     = OUT_BITS'(grant);
    r.occupancy       = OUT_BITS'(occ_cnt);
    r.waiting_zero    = OUT_BITS'(wait_cnt[0]);
    r.waiting_one     = OUT_BITS'(wait_cnt[1]);
    r.open_direction  = open_dir_q;
    r.fault           = flt;
    return r;
  endfunction

  task automatic check_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10)
        $display("result %0d: %s expected %0d, got %0d", result_idx, what, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wait_cnt[0] = 0;
      wait_cnt[1] = 0;
      occ_cnt     = 0;
      open_dir_q  = DIR_NONE;
      batch_cnt   = 0;
      pref_q      = 1'b0;
      batch_cap_q = BATCH_CAP_RESET;
      predicted_results.delete();
      pending_o <= 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) batch_cap_q = cfg_i.batch_cap;
      if (evt_i.valid && evt_i.ready)
        predicted_results.push_back(next_grant(evt_i.kind, evt_i.direction));
      if (res_i.valid && res_i.ready) begin
        if (predicted_results.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("result %0d: transfer with no event outstanding", result_idx);
        end else begin
          oldest = predicted_results.pop_front();
          check_field("grant_direction", oldest.grant_direction, res_i.grant_direction);
          check_field("grant_count", oldest.grant_count, res_i.grant_count);
          check_field("occupancy", oldest.occupancy, res_i.occupancy);
          check_field("waiting_zero", oldest.waiting_zero, res_i.waiting_zero);
          check_field("waiting_one", oldest.waiting_one, res_i.waiting_one);
          check_field("open_direction", oldest.open_direction, res_i.open_direction);
          check_field("fault", oldest.fault, res_i.fault);
        end
        result_idx++;
      end
      pending_o <= predicted_results.size();
    end
  end

endmodule

// ----- verif/two_direction_batch_arbiter_core_test.sv -----
// Testbench top of the two-direction batch arbiter: clock, reset, traffic and verdict.
module two_direction_batch_arbiter_core_test;
  import tdba_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        steady;
  int unsigned fail_cnt;
  int unsigned pending;
  int unsigned sent;
  int unsigned hold_ask;

  tdba_evt_if evt_if ();
  tdba_cfg_if cfg_if ();
  tdba_res_if res_if ();

  two_direction_batch_arbiter_core uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .evt_i  (evt_if),
    .cfg_i  (cfg_if),
    .res_o  (res_if)
  );

  tdba_grant_checker checker_i (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .evt_i     (evt_if),
    .cfg_i     (cfg_if),
    .res_i     (res_if),
    .errors_o  (fail_cnt),
    .pending_o (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic int unsigned pause_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_event(logic kind, logic dir);
    int unsigned n;
    n = steady ? 0 : pause_len();
    if (n != 0) begin
      evt_if.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    evt_if.valid     <= 1'b1;
    evt_if.kind      <= kind;
    evt_if.direction <= dir;
    @(posedge clk);
    while (!evt_if.ready) @(posedge clk);
    sent++;
  endtask

  // hold off new events until every outstanding result has been transferred
  task automatic drain();
    evt_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_cap(logic [MB_BITS-1:0] v);
    drain();
    cfg_if.valid     <= 1'b1;
    cfg_if.batch_cap <= v;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    int unsigned stall_left;
    int unsigned hold_left;
    stall_left = 0;
    hold_left  = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_ask != 0) begin
        hold_left = 400;
        hold_ask  = 0;
      end
      if (hold_left != 0) begin
        res_if.ready <= 1'b0;
        hold_left--;
      end else if (steady) begin
        res_if.ready <= 1'b1;
      end else if (stall_left != 0) begin
        res_if.ready <= 1'b0;
        stall_left--;
      end else begin
        res_if.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pause_len();
      end
    end
  end

  initial begin
    int unsigned phase;
    int unsigned len;
    logic        fdir;
    logic [MB_BITS-1:0] cap;
    evt_if.valid     <= 1'b0;
    evt_if.kind      <= KIND_ARRIVE;
    evt_if.direction <= 1'b0;
    cfg_if.valid     <= 1'b0;
    cfg_if.batch_cap <= '0;
    steady   = 1'b0;
    hold_ask = 0;
    sent     = 0;
    rst_n    = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    send_event(KIND_LEAVE, 1'b0);
    send_event(KIND_LEAVE, 1'b1);
    send_event(KIND_ARRIVE, 1'b0);
    send_event(KIND_ARRIVE, 1'b1);
    repeat (5) send_event(KIND_ARRIVE, 1'b0);
    send_event(KIND_ARRIVE, 1'b1);
    repeat (4) send_event(KIND_LEAVE, 1'b0);
    repeat (2) send_event(KIND_ARRIVE, 1'b1);
    send_event(KIND_ARRIVE, 1'b1);
    write_cap(8'd8);
    repeat (4) send_event(KIND_LEAVE, 1'b1);

    phase = 0;
    while (sent < 1820) begin
      case ($urandom_range(0, 5))
        0:       cap = 8'd1;
        1:       cap = 8'd255;
        2:       cap = 8'd0;
        3:       cap = 8'd2;
        default: cap = MB_BITS'($urandom_range(1, 16));
      endcase
      write_cap(cap);
      steady = (phase % 3 == 0);
      if (phase % 4 == 1) begin
        fdir = 1'($urandom_range(0, 1));
        repeat (300) send_event(KIND_ARRIVE, fdir);
        repeat (300) send_event(KIND_LEAVE, 1'($urandom_range(0, 1)));
      end else begin
        if (phase == 2) hold_ask = 1;
        len = $urandom_range(60, 160);
        repeat (len)
          send_event(($urandom_range(0, 99) < 52) ? KIND_ARRIVE : KIND_LEAVE,
                     1'($urandom_range(0, 1)));
      end
      steady = 1'b0;
      phase++;
    end

    drain();
    repeat (10) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
